/* design/dns_query_name_extractor_defines.svh */
// ---------------------------------------------------------------------------
// dns query name extractor: assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef DNS_QUERY_NAME_EXTRACTOR_DEFINES_SVH
`define DNS_QUERY_NAME_EXTRACTOR_DEFINES_SVH

// property checked only outside reset
`define DQX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define DQX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dnsqx_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dnsqx_pkg
// types and constants shared by the dns query name extractor
// ---------------------------------------------------------------------------
package dnsqx_pkg;

  // sizing
  localparam int MAX_PACKET_BYTES = 65535;
  localparam int MAX_LABELS       = 128;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int QS_W             = 7;
  localparam int LBL_W            = 8;

  // header layout
  localparam logic [3:0] IP_VERSION4   = 4'd4;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam int         PROTO_POS     = 9;
  localparam int         UDP_HDR_BYTES = 8;
  localparam int         DNS_HDR_BYTES = 12;
  localparam int         MIN_QSTART    = UDP_HDR_BYTES + DNS_HDR_BYTES;
  localparam int         SHORT_PACKET  = 40;

  // name encoding
  localparam logic [7:0] PTR_MASK = 8'hC0;
  localparam logic [7:0] DOT_CHAR = 8'd46;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_BEFORE = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_LABEL  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // end-of-packet status
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NO_NAME   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // result of one byte
  typedef struct packed {
    logic       emit;
    logic [7:0] name_char;
    logic       last;
    status_t    status;
  } dnsqx_res_t;

endpackage

/* design/dnsqx_parse.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dnsqx_parse
// per-packet parse state and the one-byte step of the header check and
// label walker; state advances on step, returns to reset after last byte
// ---------------------------------------------------------------------------
module dnsqx_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            pkt_byte,
  input  logic                  pkt_last,
  output dnsqx_pkg::dnsqx_res_t res
);
  import dnsqx_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [QS_W-1:0]  qs_r;
  logic             hdr_ok_r;
  phase_t           phase_r;
  logic [7:0]       rem_r;
  logic [LBL_W-1:0] lbl_r;
  logic             nonempty_r;
  logic             err_r;

  logic [POS_W-1:0] pos_nxt;
  logic [QS_W-1:0]  qs_nxt;
  logic             hdr_ok_nxt;
  phase_t           phase_a;
  phase_t           phase_nxt;
  logic [7:0]       rem_nxt;
  logic [LBL_W-1:0] lbl_nxt;
  logic             nonempty_nxt;
  logic             err_nxt;
  logic             err_fin;
  logic             emit;
  logic [7:0]       ch;
  status_t          status;

  // header capture: version and ihl on byte 0, protocol on byte 9
  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    qs_nxt     = qs_r;
    if (pos_r == '0) begin
      hdr_ok_nxt = (pkt_byte[7:4] == IP_VERSION4);
      qs_nxt     = QS_W'({pkt_byte[3:0], 2'b00}) + QS_W'(MIN_QSTART);
    end else if (pos_r == POS_W'(PROTO_POS)) begin
      hdr_ok_nxt = hdr_ok_r && (pkt_byte == PROTO_UDP);
    end
  end

  // label walker
  always_comb begin
    phase_a = phase_r;
    if (phase_r == PH_BEFORE && hdr_ok_nxt && pos_r >= POS_W'(MIN_QSTART) &&
        pos_r == POS_W'(qs_nxt)) begin
      phase_a = PH_LENGTH;
    end
    phase_nxt    = phase_a;
    rem_nxt      = rem_r;
    lbl_nxt      = lbl_r;
    nonempty_nxt = nonempty_r;
    err_nxt      = err_r;
    emit         = 1'b0;
    ch           = '0;
    case (phase_a)
      PH_LENGTH: begin
        if (pkt_byte == '0) begin
          phase_nxt = PH_DONE;
        end else if (lbl_r > LBL_W'(MAX_LABELS)) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else if ((pkt_byte & PTR_MASK) == PTR_MASK) begin
          phase_nxt = PH_DONE;
        end else begin
          // dot before every label but the first
          if (nonempty_r) begin
            emit = 1'b1;
            ch   = DOT_CHAR;
          end
          rem_nxt = pkt_byte;
          if (lbl_r != '1) begin
            lbl_nxt = lbl_r + 1'b1;
          end
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        emit         = 1'b1;
        ch           = pkt_byte;
        nonempty_nxt = 1'b1;
        rem_nxt      = rem_r - 1'b1;
        if (rem_nxt == '0) begin
          phase_nxt = PH_LENGTH;
        end
      end
      default: begin
      end
    endcase
  end

  // end-of-packet status
  always_comb begin
    err_fin = err_nxt || (phase_nxt == PH_LABEL);
    status  = ST_FOUND;
    if (pkt_last) begin
      if (pos_r < POS_W'(SHORT_PACKET) || !hdr_ok_nxt) begin
        status = ST_NO_NAME;
      end else if (err_fin) begin
        status = ST_MALFORMED;
      end else if (nonempty_nxt) begin
        status = ST_FOUND;
      end else begin
        status = ST_NO_NAME;
      end
    end
  end

  // saturating byte counter
  always_comb begin
    pos_nxt = pos_r;
    if (pos_r != POS_W'(MAX_PACKET_BYTES)) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign res.emit      = emit;
  assign res.name_char = ch;
  assign res.last      = pkt_last;
  assign res.status    = status;

  // state update, cleared again after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && pkt_last)) begin
      pos_r      <= '0;
      qs_r       <= '0;
      hdr_ok_r   <= 1'b0;
      phase_r    <= PH_BEFORE;
      rem_r      <= '0;
      lbl_r      <= '0;
      nonempty_r <= 1'b0;
      err_r      <= 1'b0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      qs_r       <= qs_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      phase_r    <= phase_nxt;
      rem_r      <= rem_nxt;
      lbl_r      <= lbl_nxt;
      nonempty_r <= nonempty_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

/* design/dns_query_name_extractor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dns_query_name_extractor
// pulls the dns query name out of a byte stream of ipv4/udp packets
// ---------------------------------------------------------------------------
// Usage: the input channel carries one packet byte per request, with
// in_last_byte high on the final byte of each packet. The result channel
// gives one request per name character (a dot between labels) and one on
// the packet's last byte, which carries out_packet_end and out_status
// (found, no name, malformed); a character may share that request.
// Bytes that make no character and are not last produce no result.
// A byte is accepted into the input register, and the output register loads
// the result of the combinational parse step on that input register.
// Throughput is one byte per cycle unless the receiver stalls.
// While the receiver stalls, the output request holds and a byte still
// enters the input register if that register is free; in_stall rises only
// once both registers are full. Synchronous reset empties both registers
// and returns the parser to the start of a packet.
// ---------------------------------------------------------------------------
module dns_query_name_extractor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_packet_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_name_char,
  output logic       out_char_valid,
  output logic       out_packet_end,
  output logic [1:0] out_status
);
  import dnsqx_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_cvalid_r;
  logic       out_end_r;
  status_t    out_status_r;

  logic       out_free;
  logic       step;
  dnsqx_res_t res;

  // pipeline flow
  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  dnsqx_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .pkt_byte (in_byte_r),
    .pkt_last (in_last_r),
    .res      (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_packet_byte;
      in_last_r <= in_last_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && (res.emit || res.last);
    end
  end

  always_ff @(posedge clk) begin
    if (step && (res.emit || res.last) && out_free) begin
      out_char_r   <= res.name_char;
      out_cvalid_r <= res.emit;
      out_end_r    <= res.last;
      out_status_r <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_name_char  = out_char_r;
  assign out_char_valid = out_cvalid_r;
  assign out_packet_end = out_end_r;
  assign out_status     = out_status_r;

endmodule

/* design/dnsqx_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dnsqx_checker
// port-level checks on the result channel, bound to the top level
// ---------------------------------------------------------------------------
`include "dns_query_name_extractor_defines.svh"

module dnsqx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_packet_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_name_char,
  input logic       out_char_valid,
  input logic       out_packet_end,
  input logic [1:0] out_status
);
  import dnsqx_pkg::*;

  // reset empties the result register
  `DQX_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result request holds
  `DQX_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_name_char) && $stable(out_char_valid) && $stable(out_packet_end) && $stable(out_status), "stalled result changed")

  // every result is a character or a packet end
  `DQX_ASSERT(a_no_empty, out_valid |-> out_char_valid || out_packet_end, "result carries nothing")

  // status only meaningful at packet end, and never an unused code
  `DQX_ASSERT(a_status, out_valid |-> (out_packet_end || out_status == ST_FOUND) && out_status != 2'd3, "bad status on result")

endmodule

bind dns_query_name_extractor dnsqx_checker u_dnsqx_checker (.*);

/* tb/tb_dns_query_name_extractor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dns_query_name_extractor
// Feeds IPv4 packets byte by byte into the dns query name extractor. A
// local parser works out every name character, separator dot and
// end-of-packet status, and each output request is checked against it.
// Directed packets cover header rejection, short packets, empty and
// cut-off names and the label limit. Random
// packets follow. Both sides idle in random bursts, and the receiver holds
// off long enough to fill the block.
// ---------------------------------------------------------------------------
module tb_dns_query_name_extractor;
  import dnsqx_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_GAP    = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_BYTES = 400;

  // clock, reset and block ports
  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_packet_byte = 8'd0;
  logic       in_last_byte   = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_name_char;
  logic       out_char_valid;
  logic       out_packet_end;
  logic [1:0] out_status;

  // idling controls and receiver hold-off request
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_req   = 1'b0;
  int hold_len   = 0;

  // packet under construction
  logic [7:0] pkt[$];

  // local parser state
  logic [15:0] byte_pos;
  logic [6:0]  qname_start;
  logic        hdr_ok;
  phase_t      name_phase;
  logic [7:0]  label_left;
  logic [7:0]  label_count;
  logic        name_has_chars;
  logic        name_bad;

  // expected output requests, oldest first
  dnsqx_res_t pending_name_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  dns_query_name_extractor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_packet_byte (in_packet_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_name_char  (out_name_char),
    .out_char_valid (out_char_valid),
    .out_packet_end (out_packet_end),
    .out_status     (out_status)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // parser back to the start of a packet
  function automatic void clear_parser();
    byte_pos       = '0;
    qname_start    = '0;
    hdr_ok         = 1'b0;
    name_phase     = PH_BEFORE;
    label_left     = '0;
    label_count    = '0;
    name_has_chars = 1'b0;
    name_bad       = 1'b0;
  endfunction

  // one accepted byte: update the parser, queue the request it causes
  function automatic void predict_name_step(input logic [7:0] b, input logic last);
    dnsqx_res_t r;
    r.emit      = 1'b0;
    r.name_char = 8'd0;
    r.last      = last;
    r.status    = ST_FOUND;

    // header: version, question offset, protocol
    if (byte_pos == 0) begin
      hdr_ok      = (b[7:4] == IP_VERSION4);
      qname_start = 7'(b[3:0] * 4 + MIN_QSTART);
    end else if (byte_pos == PROTO_POS) begin
      hdr_ok = hdr_ok && (b == PROTO_UDP);
    end

    if (name_phase == PH_BEFORE && hdr_ok && byte_pos >= MIN_QSTART &&
        byte_pos == qname_start)
      name_phase = PH_LENGTH;

    // label walk
    case (name_phase)
      PH_LENGTH: begin
        if (b == 8'd0) begin
          name_phase = PH_DONE;
        end else if (label_count > MAX_LABELS) begin
          name_bad   = 1'b1;
          name_phase = PH_DONE;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          name_phase = PH_DONE;
        end else begin
          if (name_has_chars) begin
            r.emit      = 1'b1;
            r.name_char = DOT_CHAR;
          end
          label_left = b;
          if (label_count != 8'hFF)
            label_count = label_count + 8'd1;
          name_phase = PH_LABEL;
        end
      end
      PH_LABEL: begin
        r.emit         = 1'b1;
        r.name_char    = b;
        name_has_chars = 1'b1;
        label_left     = label_left - 8'd1;
        if (label_left == 8'd0)
          name_phase = PH_LENGTH;
      end
      default: ;
    endcase

    // end-of-packet status
    if (last) begin
      if (name_phase == PH_LABEL)
        name_bad = 1'b1;
      if (byte_pos < SHORT_PACKET || !hdr_ok)
        r.status = ST_NO_NAME;
      else if (name_bad)
        r.status = ST_MALFORMED;
      else if (name_has_chars)
        r.status = ST_FOUND;
      else
        r.status = ST_NO_NAME;
    end

    if (byte_pos < MAX_PACKET_BYTES)
      byte_pos = byte_pos + 16'd1;
    if (r.emit || last)
      pending_name_q.push_back(r);
    if (last)
      clear_parser();
  endfunction

  // output checker
  always @(posedge clk) begin : check_name_output
    dnsqx_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_name_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected request: char %0d valid %0b end %0b status %0d",
                   out_name_char, out_char_valid, out_packet_end, out_status);
      end else begin
        want = pending_name_q.pop_front();
        if (out_name_char !== want.name_char || out_char_valid !== want.emit ||
            out_packet_end !== want.last || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch: expected char %0d valid %0b end %0b status %0d, ",
                      "got char %0d valid %0b end %0b status %0d"},
                     want.name_char, want.emit, want.last, want.status,
                     out_name_char, out_char_valid, out_packet_end, out_status);
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stall bursts
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // send one byte request, with an optional idle burst first
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packet_byte <= b;
    in_last_byte   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_name_step(b, last);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // stop sending and let every expected request arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_name_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // header up to the question start, random filler elsewhere
  function automatic void begin_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                       input logic [7:0] proto);
    int hdr_len;
    hdr_len = ihl * 4 + MIN_QSTART;
    pkt.delete();
    pkt.push_back({ver, ihl});
    for (int i = 1; i < hdr_len; i++)
      pkt.push_back((i == PROTO_POS) ? proto : 8'($urandom));
  endfunction

  function automatic void add_label(input int len);
    pkt.push_back(8'(len));
    repeat (len) pkt.push_back(8'($urandom));
  endfunction

  function automatic void pad_to(input int total);
    while (pkt.size() < total) pkt.push_back(8'($urandom));
  endfunction

  // well-formed names, odd characters and length codes
  task automatic test_found_names();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // usual header, zero byte and top values inside a label
    begin_packet(IP_VERSION4, 4'd5, PROTO_UDP);
    add_label(3);
    pkt.push_back(8'd4);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    pkt.push_back(DOT_CHAR);
    pkt.push_back(8'h7F);
    add_label(7);
    pkt.push_back(8'h00);
    pad_to(64);
    send_packet();
    // shortest header, length codes 0x40 and 0xbf, pointer at the end
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    add_label(8'h40);
    add_label(8'hBF);
    pkt.push_back(8'hC0);
    pkt.push_back(8'h0C);
    send_packet();
    // longest header, name runs to the last byte on a label boundary
    begin_packet(IP_VERSION4, 4'd15, PROTO_UDP);
    add_label(2);
    add_label(5);
    send_packet();
    wait_drained();
  endtask

  // cases that report no name
  task automatic test_no_name();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // exactly forty bytes is short, forty-one is not
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    add_label(5);
    pkt.push_back(8'h00);
    pad_to(40);
    send_packet();
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    add_label(5);
    pkt.push_back(8'h00);
    pad_to(41);
    send_packet();
    // short packet wins over a cut-off label
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    add_label(30);
    while (pkt.size() > 40) pkt.delete(pkt.size() - 1);
    send_packet();
    // wrong version, then wrong protocol
    begin_packet(4'd6, 4'd5, PROTO_UDP);
    add_label(4);
    pkt.push_back(8'h00);
    pad_to(60);
    send_packet();
    begin_packet(4'hF, 4'd5, PROTO_UDP);
    add_label(4);
    pad_to(60);
    send_packet();
    begin_packet(IP_VERSION4, 4'd5, 8'd6);
    add_label(4);
    pkt.push_back(8'h00);
    pad_to(60);
    send_packet();
    // question start past the end of the packet
    begin_packet(IP_VERSION4, 4'd5, PROTO_UDP);
    pkt[0] = {IP_VERSION4, 4'hF};
    pad_to(70);
    send_packet();
    // empty name: zero byte, then pointer, right at the start
    begin_packet(IP_VERSION4, 4'd5, PROTO_UDP);
    pkt.push_back(8'h00);
    pad_to(50);
    send_packet();
    begin_packet(IP_VERSION4, 4'd5, PROTO_UDP);
    pkt.push_back(8'hC5);
    pkt.push_back(8'h12);
    pad_to(50);
    send_packet();
    // one-byte packet
    pkt.delete();
    pkt.push_back({IP_VERSION4, 4'd5});
    send_packet();
    wait_drained();
  endtask

  // names cut off inside a label or on a length byte
  task automatic test_malformed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    begin_packet(IP_VERSION4, 4'd5, PROTO_UDP);
    add_label(4);
    add_label(10);
    repeat (7) pkt.delete(pkt.size() - 1);
    send_packet();
    begin_packet(IP_VERSION4, 4'd5, PROTO_UDP);
    add_label(3);
    pkt.push_back(8'd9);
    send_packet();
    wait_drained();
  endtask

  // label limit: one more than the maximum is fine, the next one is not
  task automatic test_label_limit();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    repeat (MAX_LABELS + 1) add_label(1);
    pkt.push_back(8'h00);
    pad_to(pkt.size() + 4);
    send_packet();
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    repeat (MAX_LABELS + 1) add_label(1);
    add_label(2);
    pkt.push_back(8'h00);
    send_packet();
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_len   = 300;
    hold_req   = 1'b1;
    begin_packet(IP_VERSION4, 4'd0, PROTO_UDP);
    add_label(63);
    add_label(63);
    pkt.push_back(8'h00);
    pad_to(200);
    send_packet();
    wait_drained();
  endtask

  // random packets: mostly well formed, some broken headers and noise
  task automatic test_random();
    int         sent;
    int         kind;
    logic [3:0] ihl;
    sent       = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (sent < RANDOM_BYTES) begin
      // no idling in the closing stretch
      if (sent >= RANDOM_BYTES * 3 / 4) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      kind = $urandom_range(0, 9);
      ihl  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
      if (kind >= 8) begin
        pkt.delete();
        repeat ($urandom_range(1, 60)) pkt.push_back(8'($urandom));
      end else begin
        if (kind == 7)
          begin_packet(4'($urandom), ihl, 8'($urandom));
        else
          begin_packet(IP_VERSION4, ihl, PROTO_UDP);
        repeat ($urandom_range(0, 4)) add_label($urandom_range(1, 12));
        if ($urandom_range(0, 7) == 0) begin
          // name cut short
          repeat ($urandom_range(0, 2))
            if (pkt.size() > 1) pkt.delete(pkt.size() - 1);
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            pkt.push_back({2'b11, 6'($urandom)});
            pkt.push_back(8'($urandom));
          end else begin
            pkt.push_back(8'h00);
          end
          if ($urandom_range(0, 3) == 0)
            pad_to(pkt.size() + $urandom_range(0, 8));
          else
            pad_to(SHORT_PACKET + 1 + $urandom_range(0, 10));
        end
      end
      sent += pkt.size();
      send_packet();
    end
    wait_drained();
  endtask

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_found_names();
    test_no_name();
    test_malformed();
    test_label_limit();
    test_backpressure();
    test_random();
    if (mismatch_count == 0 && pending_name_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
